// ----- sv/normed_gradient_magnitude_core_assert.svh -----
// assertion macros for the normed gradient magnitude core
`ifndef NORMED_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH
`define NORMED_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NGM_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ngm assertion failed");
`define NGM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ngm assertion failed");
`define NGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ngm assertion failed");
`else
`define NGM_ASSERT_HOLDS(lbl, expr)
`define NGM_ASSERT_IMPLIES(lbl, ante, cons)
`define NGM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/ngm_pkg.sv -----
// types and constants shared by the normed gradient magnitude core
package ngm_pkg;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef pixel_t in_word_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  magnitude;
    logic        last_of_run;
    logic        frame_done;
  } out_word_t;

  // one line store entry: pixel of the latest row and of the row before at a column
  typedef struct packed {
    pixel_t newer;
    pixel_t older;
  } line_entry_t;

  typedef struct packed {
    logic row0;
    logic y_zero;
    logic first_col;
    logic second_col;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  typedef struct packed {
    pixel_t      pix;
    pixel_t      cur0;
    pixel_t      cur1;
    logic [11:0] row;
    logic [9:0]  col;
    pos_flags_t  flags;
  } stage_word_t;

  typedef struct packed {
    out_word_t [2:0] word;
    logic [1:0]      count;
  } bundle_t;

  localparam int unsigned FRAME_WIDTH_W  = 11;
  localparam int unsigned FRAME_HEIGHT_W = 12;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 2'd2;

  localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 12'd1024;

  localparam logic COLOR_MODE_MAX_CHANNEL = 1'b0;
  localparam logic COLOR_MODE_GREY        = 1'b1;

  localparam logic [7:0] MAG_MAX = 8'd255;

endpackage

// ----- sv/ngm_line_mem.sv -----
// two-row line store: one write port, two registered read ports with write bypass
module ngm_line_mem import ngm_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output line_entry_t   rd_data_a,
  output line_entry_t   rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_entry_t   wr_data
);

  line_entry_t mem [DEPTH];
  line_entry_t raw_a;
  line_entry_t raw_b;
  line_entry_t byp_data;
  logic        byp_a;
  logic        byp_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_a    <= mem[rd_addr_a];
      raw_b    <= mem[rd_addr_b];
      byp_data <= wr_data;
    end
  end

  // same-cycle write to a read address wins
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_a <= 1'b0;
      byp_b <= 1'b0;
    end else if (rd_en) begin
      byp_a <= wr_en && (wr_addr == rd_addr_a);
      byp_b <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  assign rd_data_a = byp_a ? byp_data : raw_a;
  assign rd_data_b = byp_b ? byp_data : raw_b;

endmodule

// ----- sv/ngm_grad.sv -----
// gradient stage: grey conversion, pixel distances and up to three magnitudes per pixel
module ngm_grad import ngm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        color_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  stage_word_t stage,
  input  pixel_t      up,
  input  pixel_t      above,
  input  pixel_t      right,
  input  pixel_t      left,
  output logic        bnd_valid,
  input  logic        bnd_ready,
  output bundle_t     bnd
);

  function automatic logic [7:0] grey_of(pixel_t q);
    logic [21:0] acc;
    acc = 22'(q.pixel_blue) * 22'd1868 + 22'(q.pixel_green) * 22'd9617
        + 22'(q.pixel_red) * 22'd4899 + 22'd8192;
    return acc[21:14];
  endfunction

  // in grey mode the grey value sits in the blue lane, so max-channel distance applies
  function automatic pixel_t operand(pixel_t q, logic mode);
    pixel_t o;
    o = q;
    if (mode == COLOR_MODE_GREY) begin
      o.pixel_red   = 8'd0;
      o.pixel_green = 8'd0;
      o.pixel_blue  = grey_of(q);
    end
    return o;
  endfunction

  function automatic logic [7:0] absdiff8(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] pix_dist(pixel_t a, pixel_t b);
    logic [7:0] db;
    logic [7:0] dg;
    logic [7:0] dr;
    logic [7:0] m;
    db = absdiff8(a.pixel_blue, b.pixel_blue);
    dg = absdiff8(a.pixel_green, b.pixel_green);
    dr = absdiff8(a.pixel_red, b.pixel_red);
    m  = (dg > db) ? dg : db;
    m  = (dr > m) ? dr : m;
    return m;
  endfunction

  function automatic logic [7:0] sat_sum(logic [8:0] gx, logic [8:0] gy);
    logic [9:0] s;
    s = 10'(gx) + 10'(gy);
    return (s > 10'd255) ? MAG_MAX : s[7:0];
  endfunction

  logic        s2_valid;
  logic        s2_go;
  stage_word_t s2_word;
  pixel_t      op_up;
  pixel_t      op_above;
  pixel_t      op_right;
  pixel_t      op_left;

  logic [7:0] d_ru, d_ul, d_lr, d_pu, d_ap, d_pc0, d_c1p, d_c0l;
  logic [8:0] gx0, gy0, gx1, gy1, gx2, gy2;
  logic       has1;
  logic       has2;
  logic [1:0] count;
  out_word_t  r0, r1, r2;

  assign s2_go    = s2_valid && ((count == 2'd0) || bnd_ready);
  assign in_ready = !s2_valid || s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s2_word.pix   <= operand(stage.pix, color_mode);
      s2_word.cur0  <= operand(stage.cur0, color_mode);
      s2_word.cur1  <= operand(stage.cur1, color_mode);
      s2_word.row   <= stage.row;
      s2_word.col   <= stage.col;
      s2_word.flags <= stage.flags;
      op_up         <= operand(up, color_mode);
      op_above      <= operand(above, color_mode);
      op_right      <= operand(right, color_mode);
      op_left       <= operand(left, color_mode);
    end
  end

  always_comb begin
    d_ru  = pix_dist(op_right, op_up);
    d_ul  = pix_dist(op_up, op_left);
    d_lr  = pix_dist(op_left, op_right);
    d_pu  = pix_dist(s2_word.pix, op_up);
    d_ap  = pix_dist(op_above, s2_word.pix);
    d_pc0 = pix_dist(s2_word.pix, s2_word.cur0);
    d_c1p = pix_dist(s2_word.cur1, s2_word.pix);
    d_c0l = pix_dist(s2_word.cur0, op_left);

    // row above the arriving pixel
    if (s2_word.flags.first_col) begin
      gx0 = {d_ru, 1'b0};
    end else if (s2_word.flags.last_col) begin
      gx0 = {d_ul, 1'b0};
    end else begin
      gx0 = {1'b0, d_lr};
    end
    gy0 = s2_word.flags.y_zero ? {d_pu, 1'b0} : {1'b0, d_ap};

    // bottom row, one column behind
    gx1 = s2_word.flags.second_col ? {d_pc0, 1'b0} : {1'b0, d_c1p};
    gy1 = {d_c0l, 1'b0};

    // bottom-right corner
    gx2 = {d_pc0, 1'b0};
    gy2 = {d_pu, 1'b0};

    has1 = s2_word.flags.last_row && !s2_word.flags.first_col;
    has2 = s2_word.flags.last_row && s2_word.flags.last_col;

    if (s2_word.flags.row0) begin
      count = 2'd0;
    end else begin
      count = 2'd1 + 2'(has1) + 2'(has2);
    end

    r0.out_row     = s2_word.row - 12'd1;
    r0.out_col     = s2_word.col;
    r0.magnitude   = sat_sum(gx0, gy0);
    r0.last_of_run = !has1;
    r0.frame_done  = 1'b0;

    r1.out_row     = s2_word.row;
    r1.out_col     = s2_word.col - 10'd1;
    r1.magnitude   = sat_sum(gx1, gy1);
    r1.last_of_run = !has2;
    r1.frame_done  = 1'b0;

    r2.out_row     = s2_word.row;
    r2.out_col     = s2_word.col;
    r2.magnitude   = sat_sum(gx2, gy2);
    r2.last_of_run = 1'b1;
    r2.frame_done  = 1'b1;

    bnd.word  = {r2, r1, r0};
    bnd.count = count;
  end

  assign bnd_valid = s2_valid && (count != 2'd0);

endmodule

// ----- sv/ngm_out_seq.sv -----
// output register that hands out the words of one pixel's run in order
module ngm_out_seq import ngm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      bnd_valid,
  output logic      bnd_ready,
  input  bundle_t   bnd,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  bundle_t    held;
  logic [1:0] idx;
  logic       busy;
  logic       at_last;

  assign at_last   = (idx == held.count - 2'd1);
  assign bnd_ready = !busy || (result_ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (bnd_valid && bnd_ready) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && result_ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_valid && bnd_ready) begin
      held <= bnd;
    end
  end

  assign result_valid = busy;
  assign result       = held.word[idx];

endmodule

// ----- sv/normed_gradient_magnitude_core.sv -----
// top level of the normed gradient magnitude core
// Usage:
//   pixel channel (pixel_valid/pixel_ready/pixel) takes BGR pixels in raster order.
//   result channel (result_valid/result_ready/result) gives one magnitude word per
//   handshake, tagged with its row and column; last_of_run marks the final word
//   caused by one pixel, frame_done the word for the bottom-right pixel.
//   cfg channel writes frame_width, frame_height and color_mode by index; a write
//   to one of them restarts the frame. Write only while no pixel is in flight.
//   While pixel (r,c) is taken, the word for (r-1,c) is produced; the bottom row
//   is flushed along with its own pixels. The top row of a frame gives no word.
//   A pixel's first word passes the s1, gradient and output registers.
//   Throughput: one pixel per cycle while result_ready holds high; on the bottom row
//   two words per pixel past its first column (three at its last column), and the
//   one-word-per-cycle result port then holds back pixel_ready there.
//   The line store is read at two columns and written back once per pixel.
//   Reset clears counters, stage valids and registers to their defaults; the line
//   store needs no clearing pass. If result_ready is low the stages behind the
//   output register keep filling, then pixel_ready drops; no word is lost.
module normed_gradient_magnitude_core import ngm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  in_word_t               pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_word_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "normed_gradient_magnitude_core_assert.svh"

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic                      color_mode;
  logic                      cfg_hit;
  logic                      cfg_restart;

  logic [COL_W-1:0]          w_last;
  logic [FRAME_HEIGHT_W-1:0] h_last;

  logic [FRAME_HEIGHT_W-1:0] row;
  logic [COL_W-1:0]          col;
  pixel_t                    cur0;
  pixel_t                    cur1;
  logic                      accept;

  logic                      s1_valid;
  logic                      s1_go;
  stage_word_t               s1_word;
  logic [COL_W-1:0]          s1_col;
  pixel_t                    up_prev;
  logic                      grad_ready;

  logic [COL_W-1:0]          addr_b;
  line_entry_t               rd_a;
  line_entry_t               rd_b;
  line_entry_t               wr_data;

  logic                      bnd_valid;
  logic                      bnd_ready;
  bundle_t                   bnd;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index) inside
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_COLOR_MODE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cfg_restart = cfg_valid && cfg_ready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      color_mode   <= COLOR_MODE_MAX_CHANNEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // last column and last row of the effective frame
  always_comb begin
    if (frame_width < 11'd2) begin
      w_last = COL_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(frame_width - 11'd1);
    end
    if (frame_height < 12'd2) begin
      h_last = 12'd1;
    end else begin
      h_last = frame_height - 12'd1;
    end
  end

  assign s1_go       = s1_valid && grad_ready;
  assign pixel_ready = !s1_valid || grad_ready;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      row  <= '0;
      col  <= '0;
      cur0 <= '0;
      cur1 <= '0;
    end else if (accept) begin
      cur0 <= pixel;
      cur1 <= cur0;
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + 12'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word.pix              <= pixel;
      s1_word.cur0             <= cur0;
      s1_word.cur1             <= cur1;
      s1_word.row              <= row;
      s1_word.col              <= 10'(col);
      s1_word.flags.row0       <= (row == 12'd0);
      s1_word.flags.y_zero     <= (row == 12'd1);
      s1_word.flags.first_col  <= (col == '0);
      s1_word.flags.second_col <= (col == COL_W'(1));
      s1_word.flags.last_col   <= (col == w_last);
      s1_word.flags.last_row   <= (row == h_last);
      s1_col                   <= col;
    end
  end

  // pixel of the row above, one column to the left
  always_ff @(posedge clk) begin
    if (s1_go) begin
      up_prev <= rd_a.newer;
    end
  end

  assign addr_b        = (col == w_last) ? col : col + COL_W'(1);
  assign wr_data.newer = s1_word.pix;
  assign wr_data.older = rd_a.newer;

  ngm_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (col),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (s1_go),
    .wr_addr   (s1_col),
    .wr_data   (wr_data)
  );

  ngm_grad u_grad (
    .clk        (clk),
    .rst        (rst),
    .color_mode (color_mode),
    .in_valid   (s1_valid),
    .in_ready   (grad_ready),
    .stage      (s1_word),
    .up         (rd_a.newer),
    .above      (rd_a.older),
    .right      (rd_b.newer),
    .left       (up_prev),
    .bnd_valid  (bnd_valid),
    .bnd_ready  (bnd_ready),
    .bnd        (bnd)
  );

  ngm_out_seq u_out_seq (
    .clk          (clk),
    .rst          (rst),
    .bnd_valid    (bnd_valid),
    .bnd_ready    (bnd_ready),
    .bnd          (bnd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `NGM_ASSERT_HOLDS(a_pos_in_frame, (col <= w_last) && (row <= h_last))
  `NGM_ASSERT_IMPLIES(a_done_ends_run, result_valid && result.frame_done, result.last_of_run)
  `NGM_ASSERT_NEXT(a_run_continues, result_valid && result_ready && !result.last_of_run, result_valid)

endmodule
